// ===== hdl/srgt_pkg.sv =====
// Shared constants, types and build-time taper table functions for the
// source/receiver gradient taper. Depends on nothing.
package srgt_pkg;

   localparam int MAX_RECEIVERS_DEF = 256;
   localparam int GRID_BITS_DEF     = 12;
   localparam int TAPER_ENTRIES_DEF = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_COL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ROW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_SQ    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SCALE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RCV_COUNT    = 3'd4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_TAPER = 1'b1;

   localparam logic [16:0] TAPER_ONE = 17'd65536;

   localparam longint unsigned ONE_Q30      = 64'd1073741824;
   localparam longint unsigned FLOOR_Q30    = 64'd1073742;
   localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
   localparam longint unsigned EXPONENT_Q16 = 64'd437123;

   // Control handed to every cell of the receiver ring.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bit_w;
      rem   = v;
      res   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Restoring division for the build-time table math.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor denominators (2n)(2n+1).
   function automatic longint unsigned sin_den(input int n);
      unique case (n)
         1: return 64'd6;
         2: return 64'd20;
         3: return 64'd42;
         4: return 64'd72;
         5: return 64'd110;
         default: return 64'd156;
      endcase
   endfunction

   function automatic longint unsigned sin_q30(input longint unsigned x_q16);
      longint unsigned y;
      longint unsigned y2;
      longint unsigned term;
      longint sum;
      y    = (x_q16 * HALF_PI_Q30) >> 16;
      y2   = (y * y) >> 30;
      term = y;
      sum  = longint'(y);
      for (int n = 1; n <= 6; n++) begin
         term = udiv64((term * y2) >> 30, sin_den(n));
         if ((n & 1) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return longint'(sum);
   endfunction

   function automatic longint unsigned pow_q30(input longint unsigned s);
      longint unsigned res;
      longint unsigned r;
      res = ONE_Q30;
      r   = s;
      for (int i = 0; i < int'(EXPONENT_Q16 >> 16); i++) res = (res * s) >> 30;
      for (int i = 1; i <= 16; i++) begin
         r = isqrt64(r << 30);
         if (r > ONE_Q30) r = ONE_Q30;
         if (((EXPONENT_Q16 >> (16 - i)) & 64'd1) != 0) res = (res * r) >> 30;
      end
      return res;
   endfunction

   function automatic logic [16:0] taper_entry(input longint unsigned x_raw);
      longint unsigned x;
      longint unsigned v;
      longint unsigned q;
      x = (x_raw > 64'd65536) ? 64'd65536 : x_raw;
      v = FLOOR_Q30 + (((ONE_Q30 - FLOOR_Q30) * pow_q30(sin_q30(x))) >> 30);
      q = v >> 14;
      if (q > 64'd65536) q = 64'd65536;
      return q[16:0];
   endfunction

endpackage

// ===== hdl/srgt_req_if.sv =====
// Input channel of the gradient taper: valid/ready plus one load or sample item.
// Depends on nothing.
interface srgt_req_if #(parameter int GRID_BITS = 12);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [7:0]           slot;
   logic [GRID_BITS-1:0] col;
   logic [GRID_BITS-1:0] row;
   logic signed [31:0]   grad_value;

   modport source(output valid, operation, slot, col, row, grad_value, input ready);
   modport sink(input valid, operation, slot, col, row, grad_value, output ready);
endinterface

// ===== hdl/srgt_rsp_if.sv =====
// Result channel of the gradient taper: valid/ready plus one tapered item.
// Depends on nothing.
interface srgt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] tapered_value;
   logic [16:0]        taper_product;

   modport source(output valid, tapered_value, taper_product, input ready);
   modport sink(input valid, tapered_value, taper_product, output ready);
endinterface

// ===== hdl/source_receiver_gradient_taper.sv =====
// Top level of the source/receiver gradient taper.
// Depends on srgt_pkg, srgt_req_if, srgt_rsp_if, srgt_cell and srgt_taper_rom.

// A load item writes one receiver position into a ring of MAX_RECEIVERS cells
// and yields no result. A sample item yields one result: the block rotates
// the ring once around (the source first, then each receiver as it reaches
// the head cell; only the source and the first receiver_count receivers are
// issued), feeds each issued position into a five-stage distance/index/table
// pipeline and multiplies the running Q1.16 taper product by the table value
// of each position inside the radius, in order. The ring always turns a full
// rotation, whatever receiver_count is, and the pipeline then drains before
// the result is written. One sample is worked on at a time; the result waits
// in an output register, and the block takes load items and the next sample
// while it waits. The user must write registers through the csr_ port only
// while the block is idle; the block itself does not enforce this.
module source_receiver_gradient_taper #(
   parameter int MAX_RECEIVERS = srgt_pkg::MAX_RECEIVERS_DEF,
   parameter int GRID_BITS     = srgt_pkg::GRID_BITS_DEF,
   parameter int TAPER_ENTRIES = srgt_pkg::TAPER_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   srgt_req_if.sink                         req_chan,
   srgt_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [srgt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [srgt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int CNT_W = $clog2(MAX_RECEIVERS + 1);
   localparam int IDX_W = $clog2(TAPER_ENTRIES);
   localparam int A_W   = (GRID_BITS + 4 > 16) ? GRID_BITS + 4 : 16;
   localparam int SQ_W  = 2 * A_W + 1;
   localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH} state_type;

   // Configuration registers.
   logic [15:0] src_col_ff, src_row_ff;
   logic [23:0] radius_sq_ff;
   logic [31:0] scale_ff;
   logic [8:0]  rcv_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         radius_sq_ff <= '0;
         scale_ff     <= '0;
         rcv_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            srgt_pkg::CSR_SOURCE_COL:  src_col_ff   <= csr_wdata[15:0];
            srgt_pkg::CSR_SOURCE_ROW:  src_row_ff   <= csr_wdata[15:0];
            srgt_pkg::CSR_RADIUS_SQ:   radius_sq_ff <= csr_wdata[23:0];
            srgt_pkg::CSR_INDEX_SCALE: scale_ff     <= csr_wdata;
            srgt_pkg::CSR_RCV_COUNT:   rcv_count_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Saturate the receiver count to the ring length.
   logic [CNT_W-1:0] count_eff;
   always_comb begin
      if (32'(rcv_count_ff) > MAX_RECEIVERS) count_eff = CNT_W'(MAX_RECEIVERS);
      else                                   count_eff = CNT_W'(rcv_count_ff);
   end

   // Control state.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    term_ff, term_in;
   logic [16:0]         acc_ff, acc_in;
   logic                rsp_v_ff, rsp_v_in;
   logic signed [31:0]  rsp_val_ff, rsp_val_in;
   logic [16:0]         rsp_prod_ff, rsp_prod_in;

   // Sample being worked on.
   logic [GRID_BITS-1:0] samp_col_ff, samp_row_ff;
   logic signed [31:0]   samp_grad_ff;

   logic [4:0]  stage_v_ff;
   logic        inside5_ff;
   logic [16:0] rom_taper;

   logic accept, sample_acc, load_acc, issue, shift;
   assign accept     = req_chan.valid && req_chan.ready;
   assign sample_acc = accept && (req_chan.operation == srgt_pkg::OP_TAPER);
   assign load_acc   = accept && (req_chan.operation == srgt_pkg::OP_LOAD);
   assign issue      = (state_ff == ST_RUN) && (term_ff <= count_eff);
   assign shift      = (state_ff == ST_RUN) && (term_ff != '0);

   assign req_chan.ready = (state_ff == ST_IDLE);

   logic signed [49:0] final_prod;
   assign final_prod = 50'(samp_grad_ff) * $signed({33'd0, acc_ff});

   always_comb begin
      state_in    = state_ff;
      term_in     = term_ff;
      acc_in      = acc_ff;
      rsp_v_in    = rsp_v_ff && !rsp_chan.ready;
      rsp_val_in  = rsp_val_ff;
      rsp_prod_in = rsp_prod_ff;
      // Fold in each table value inside the radius as it leaves the pipeline.
      if (stage_v_ff[4] && inside5_ff) begin
         acc_in = 17'((34'(acc_ff) * 34'(rom_taper)) >> 16);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_acc) begin
               state_in = ST_RUN;
               term_in  = '0;
               acc_in   = srgt_pkg::TAPER_ONE;
            end
         end
         ST_RUN: begin
            term_in = term_ff + 1'b1;
            if (term_ff == CNT_W'(MAX_RECEIVERS)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (stage_v_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold the result until the output register is free.
            if (!rsp_v_ff || rsp_chan.ready) begin
               rsp_v_in    = 1'b1;
               rsp_val_in  = final_prod[47:16];
               rsp_prod_in = acc_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
         acc_ff   <= srgt_pkg::TAPER_ONE;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         acc_ff   <= acc_in;
         rsp_v_ff <= rsp_v_in;
      end
      rsp_val_ff  <= rsp_val_in;
      rsp_prod_ff <= rsp_prod_in;
   end

   assign rsp_chan.valid         = rsp_v_ff;
   assign rsp_chan.tapered_value = rsp_val_ff;
   assign rsp_chan.taper_product = rsp_prod_ff;

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         samp_col_ff  <= req_chan.col;
         samp_row_ff  <= req_chan.row;
         samp_grad_ff <= req_chan.grad_value;
      end
   end

   // Receiver ring: cell 0 is the head, each cell takes from the next one.
   logic [GRID_BITS-1:0] ring_col [MAX_RECEIVERS];
   logic [GRID_BITS-1:0] ring_row [MAX_RECEIVERS];

   for (genvar i = 0; i < MAX_RECEIVERS; i++) begin : g_cell
      localparam int NEXT = (i == MAX_RECEIVERS - 1) ? 0 : i + 1;
      srgt_pkg::cell_ctrl_type ctrl;
      assign ctrl.shift = shift;
      assign ctrl.load  = load_acc && (32'(req_chan.slot) == i);
      srgt_cell #(.GRID_BITS(GRID_BITS)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_col (req_chan.col),
         .load_row (req_chan.row),
         .next_col (ring_col[NEXT]),
         .next_row (ring_row[NEXT]),
         .col      (ring_col[i]),
         .row      (ring_row[i])
      );
   end

   // Stage 1: absolute distances in sixteenth grid units (Q4).
   logic [A_W-1:0]      pos_col, pos_row, ref_col, ref_row;
   logic signed [A_W:0] dx, dy;
   logic [A_W-1:0]      d1x_ff, d1y_ff;

   always_comb begin
      pos_col = A_W'({samp_col_ff, 4'b0});
      pos_row = A_W'({samp_row_ff, 4'b0});
      if (term_ff == '0) begin
         ref_col = A_W'(src_col_ff);
         ref_row = A_W'(src_row_ff);
      end else begin
         ref_col = A_W'({ring_col[0], 4'b0});
         ref_row = A_W'({ring_row[0], 4'b0});
      end
      dx = $signed({1'b0, pos_col}) - $signed({1'b0, ref_col});
      dy = $signed({1'b0, pos_row}) - $signed({1'b0, ref_row});
   end

   // Stage 2: squared distance in Q8.
   logic [SQ_W-1:0] dsq2_ff;
   // Stage 3: radius check and low word for indexing.
   logic            inside3_ff, inside4_ff;
   logic [31:0]     dlo3_ff;
   logic [CMP_W-1:0] dsq_ext, rad_ext;
   // Stage 4: index product.
   logic [63:0]     m4_ff;
   logic [IDX_W-1:0] rom_idx;

   assign dsq_ext = CMP_W'(dsq2_ff);
   assign rad_ext = CMP_W'({radius_sq_ff, 8'b0});

   // Saturate the table index to the last entry.
   always_comb begin
      if (m4_ff[63:24] > 40'(TAPER_ENTRIES - 1)) rom_idx = IDX_W'(TAPER_ENTRIES - 1);
      else                                       rom_idx = m4_ff[24 +: IDX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= {stage_v_ff[3:0], issue};
      end
      d1x_ff     <= dx[A_W] ? A_W'(-dx) : A_W'(dx);
      d1y_ff     <= dy[A_W] ? A_W'(-dy) : A_W'(dy);
      dsq2_ff    <= SQ_W'(d1x_ff) * SQ_W'(d1x_ff) + SQ_W'(d1y_ff) * SQ_W'(d1y_ff);
      inside3_ff <= dsq_ext <= rad_ext;
      dlo3_ff    <= dsq_ext[31:0];
      inside4_ff <= inside3_ff;
      m4_ff      <= 64'(dlo3_ff) * 64'(scale_ff);
      inside5_ff <= inside4_ff;
   end

   srgt_taper_rom #(.TAPER_ENTRIES(TAPER_ENTRIES)) u_rom (
      .clock (clock),
      .index (rom_idx),
      .taper (rom_taper)
   );

   // The running product never grows above one.
   assert property (@(posedge clock) disable iff (reset)
      acc_ff <= srgt_pkg::TAPER_ONE)
      else $error("taper product above one");

   // A result is taken only after the pipeline has drained.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (stage_v_ff == '0))
      else $error("result taken with terms in flight");

   // An accepted sample starts at the source term.
   assert property (@(posedge clock) disable iff (reset)
      sample_acc |=> (state_ff == ST_RUN) && (term_ff == '0))
      else $error("sample did not start a ring pass");

   // The ring leaves the run state only after a full rotation.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (term_ff != CNT_W'(MAX_RECEIVERS)) |=> (state_ff == ST_RUN))
      else $error("ring pass cut short");
endmodule

// ===== hdl/srgt_cell.sv =====
// One cell of the receiver ring: holds one receiver position, loads it or
// takes its neighbor's. Depends on srgt_pkg.
module srgt_cell #(
   parameter int GRID_BITS = srgt_pkg::GRID_BITS_DEF
) (
   input  logic                    clock,
   input  srgt_pkg::cell_ctrl_type ctrl,
   input  logic [GRID_BITS-1:0]    load_col,
   input  logic [GRID_BITS-1:0]    load_row,
   input  logic [GRID_BITS-1:0]    next_col,
   input  logic [GRID_BITS-1:0]    next_row,
   output logic [GRID_BITS-1:0]    col,
   output logic [GRID_BITS-1:0]    row
);
   logic [GRID_BITS-1:0] col_ff, row_ff;
   logic [GRID_BITS-1:0] col_in, row_in;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.load) begin
         col_in = load_col;
         row_in = load_row;
      end else if (ctrl.shift) begin
         col_in = next_col;
         row_in = next_row;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
   end

   assign col = col_ff;
   assign row = row_ff;
endmodule

// ===== hdl/srgt_taper_rom.sv =====
// Sine-power taper table, filled at elaboration, with a registered read.
// Depends on srgt_pkg.
module srgt_taper_rom #(
   parameter int TAPER_ENTRIES = srgt_pkg::TAPER_ENTRIES_DEF,
   localparam int IDX_W = $clog2(TAPER_ENTRIES)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] index,
   output logic [16:0]      taper
);
   logic [16:0] rom_table [TAPER_ENTRIES];
   logic [16:0] taper_ff;

   for (genvar k = 0; k < TAPER_ENTRIES; k++) begin : g_entry
      localparam longint unsigned X_RAW =
         srgt_pkg::isqrt64(srgt_pkg::udiv64(64'(k) << 32, 64'(TAPER_ENTRIES - 1)));
      localparam logic [16:0] VALUE = srgt_pkg::taper_entry(X_RAW);
      assign rom_table[k] = VALUE;
   end

   always_ff @(posedge clock) begin
      taper_ff <= rom_table[index];
   end

   assign taper = taper_ff;
endmodule

// ===== test/source_receiver_gradient_taper_tb.sv =====
// Self-checking testbench for source_receiver_gradient_taper: drives load and sample
// items with random idling and checks each result against an in-bench predictor.
// Depends on srgt_pkg, srgt_req_if, srgt_rsp_if and the block under test.
module source_receiver_gradient_taper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RCV_SLOTS   = 256;
   localparam int ROM_DEPTH   = 1024;
   localparam int DRAIN_WAIT  = RCV_SLOTS + 16;   // sample latency plus margin
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic               operation;
      logic [7:0]         slot;
      logic [11:0]        col;
      logic [11:0]        row;
      logic signed [31:0] grad_value;
   } grad_item_type;

   typedef struct {
      logic signed [31:0] tapered_value;
      logic [16:0]        taper_product;
   } tapered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we    = 1'b0;
   logic [srgt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [srgt_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   srgt_req_if #(.GRID_BITS(12)) req();
   srgt_rsp_if                   rsp();

   source_receiver_gradient_taper u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Predictor state: our own copy of the settings, the receiver table and the taper ROM.
   logic [15:0] src_col_q4, src_row_q4;
   logic [23:0] radius_cfg;
   logic [31:0] scale_cfg;
   logic [8:0]  count_cfg;
   logic [11:0] rx_col [RCV_SLOTS];
   logic [11:0] rx_row [RCV_SLOTS];
   logic [16:0] damp_table [ROM_DEPTH];

   tapered_type expected_results[$];
   int          fail_count    = 0;
   int          send_idle_pct = 23;
   int          recv_idle_pct = 49;

   // ---------------------------------------------------------------------------
   // Taper ROM, rebuilt independently: floor square root by binary search,
   // sine by Taylor series, fractional power by repeated square roots.
   // ---------------------------------------------------------------------------
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint unsigned quarter_sine(longint unsigned x_q16);
      longint unsigned y, y2, term;
      longint acc;
      y    = (x_q16 * 64'd1686629713) >> 16;
      y2   = (y * y) >> 30;
      term = y;
      acc  = longint'(y);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * y2) >> 30) / longint'((2 * n) * (2 * n + 1));
         // alternate the sign of successive odd powers
         acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      return longint'(acc);
   endfunction

   function automatic longint unsigned raise_q30(longint unsigned s);
      longint unsigned acc, root;
      longint unsigned expo;
      expo = 64'd437123;
      acc  = 64'd1073741824;
      root = s;
      for (int i = 0; i < int'(expo >> 16); i++) acc = (acc * s) >> 30;
      // each fraction bit of the exponent takes one more square root
      for (int i = 1; i <= 16; i++) begin
         root = floor_sqrt(root << 30);
         if (root > 64'd1073741824) root = 64'd1073741824;
         if (expo[16 - i]) acc = (acc * root) >> 30;
      end
      return acc;
   endfunction

   initial begin
      longint unsigned x, v, q;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         x = floor_sqrt((longint'(k) << 32) / (ROM_DEPTH - 1));
         if (x > 64'd65536) x = 64'd65536;
         v = 64'd1073742 + (((64'd1073741824 - 64'd1073742) * raise_q30(quarter_sine(x))) >> 30);
         q = v >> 14;
         damp_table[k] = (q > 64'd65536) ? 17'd65536 : q[16:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------
   function automatic logic [16:0] taper_factor(longint unsigned dsq_q8);
      longint unsigned idx;
      if (dsq_q8 > (longint'(radius_cfg) << 8)) return srgt_pkg::TAPER_ONE;
      idx = (dsq_q8 * longint'(scale_cfg)) >> 24;
      if (idx > ROM_DEPTH - 1) idx = ROM_DEPTH - 1;   // saturate past the last entry
      return damp_table[idx];
   endfunction

   function automatic longint unsigned square_dist(longint dx, longint dy);
      return longint'(dx * dx + dy * dy);
   endfunction

   // Update the receiver table for a load; return 1 and fill the result for a sample.
   function automatic bit predict_taper(grad_item_type it, output tapered_type res);
      longint unsigned prod;
      longint          scaled;
      int              used;
      res = '{tapered_value: '0, taper_product: '0};
      if (it.operation == srgt_pkg::OP_LOAD) begin
         rx_col[it.slot] = it.col;
         rx_row[it.slot] = it.row;
         return 1'b0;
      end
      prod = taper_factor(square_dist(longint'(it.col) * 16 - longint'(src_col_q4),
                                      longint'(it.row) * 16 - longint'(src_row_q4)));
      used = (count_cfg > RCV_SLOTS) ? RCV_SLOTS : int'(count_cfg);
      for (int n = 0; n < used; n++)
         prod = (prod * taper_factor(square_dist(longint'(it.col) - longint'(rx_col[n]),
                                                 longint'(it.row) - longint'(rx_row[n])) << 8))
                >> 16;
      scaled = longint'(it.grad_value) * longint'(prod);
      scaled = scaled >>> 16;                  // floor, also for negative values
      res.tapered_value = scaled[31:0];
      res.taper_product = prod[16:0];
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------
   initial begin
      req.valid      = 1'b0;
      req.operation  = srgt_pkg::OP_LOAD;
      req.slot       = '0;
      req.col        = '0;
      req.row        = '0;
      req.grad_value = '0;
      rsp.ready      = 1'b0;
   end

   // Stall the result side at random; sample at the falling edge below.
   always @(posedge clock) rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Send one item, hold it until taken, then predict its result.
   task automatic send_item(grad_item_type it);
      int          gap;
      bit          taken;
      tapered_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.operation  <= it.operation;
      req.slot       <= it.slot;
      req.col        <= it.col;
      req.row        <= it.row;
      req.grad_value <= it.grad_value;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      if (predict_taper(it, res)) expected_results.push_back(res);
   endtask

   task automatic send_sample(logic [11:0] col, logic [11:0] row, logic [31:0] grad);
      send_item('{operation: srgt_pkg::OP_TAPER, slot: 8'($urandom), col: col, row: row,
                  grad_value: grad});
   endtask

   // Drop valid, let every expected result arrive, then let the block settle.
   task automatic drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write all five registers back to back; only called with the block idle.
   task automatic program_settings(logic [15:0] s_col, logic [15:0] s_row,
                                   logic [23:0] rad, logic [31:0] scl, logic [8:0] cnt);
      logic [srgt_pkg::CSR_INDEX_W-1:0] idx [5];
      logic [srgt_pkg::CSR_DATA_W-1:0]  val [5];
      idx = '{srgt_pkg::CSR_SOURCE_COL, srgt_pkg::CSR_SOURCE_ROW, srgt_pkg::CSR_RADIUS_SQ,
              srgt_pkg::CSR_INDEX_SCALE, srgt_pkg::CSR_RCV_COUNT};
      val = '{32'(s_col), 32'(s_row), 32'(rad), scl, 32'(cnt)};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      src_col_q4 = s_col;
      src_row_q4 = s_row;
      radius_cfg = rad;
      scale_cfg  = scl;
      count_cfg  = cnt;
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      tapered_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: tapered_value %0d taper_product %0d",
                   rsp.tapered_value, rsp.taper_product);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp.tapered_value !== want.tapered_value) begin
               $error("tapered_value: expected %0d, got %0d",
                      want.tapered_value, rsp.tapered_value);
               fail_count++;
            end
            if (rsp.taper_product !== want.taper_product) begin
               $error("taper_product: expected %0d, got %0d",
                      want.taper_product, rsp.taper_product);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   int stall_cycles = 0;
   always @(negedge clock) begin
      if (reset || csr_we || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("source_receiver_gradient_taper_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings, empty table: the first four samples sit on the source at radius zero, the last lies outside.
   task automatic test_after_reset();
      src_col_q4 = '0; src_row_q4 = '0; radius_cfg = '0; scale_cfg = '0; count_cfg = '0;
      send_sample(12'd0, 12'd0, 32'h7FFF_FFFF);
      send_sample(12'd0, 12'd0, 32'h8000_0000);
      send_sample(12'd0, 12'd0, 32'hFFFF_FFFF);
      send_sample(12'd0, 12'd0, 32'd1);
      send_sample(12'd4095, 12'd4095, 32'h8000_0000);   // outside: taper one
      drain();
   endtask

   // Load every slot, the corners of the grid on the first and last ones.
   task automatic test_fill_table();
      for (int s = 0; s < RCV_SLOTS; s++) begin
         logic [11:0] c, r;
         c = 12'($urandom);
         r = 12'($urandom);
         if (s == 0)   begin c = 12'd0;    r = 12'd0;    end
         if (s == 255) begin c = 12'd4095; r = 12'd4095; end
         send_item('{operation: srgt_pkg::OP_LOAD, slot: 8'(s), col: c, row: r,
                     grad_value: 32'($urandom)});
      end
      drain();
   endtask

   // Boundary, saturating count and index, extreme registers.
   task automatic test_extremes();
      // a distance of exactly 5 grid units with radius_sq 25 is inside, 24 is outside
      program_settings(16'd0, 16'd0, 24'd25, 32'h0001_0000, 9'd0);
      send_sample(12'd3, 12'd4, 32'h0001_0000);
      drain();
      program_settings(16'd0, 16'd0, 24'd24, 32'h0001_0000, 9'd0);
      send_sample(12'd3, 12'd4, 32'h0001_0000);
      drain();
      // every register at its top; count above the table saturates
      program_settings(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 9'd511);
      send_sample(12'd4095, 12'd4095, 32'h7FFF_FFFF);
      send_sample(12'd0, 12'd0, 32'h8000_0000);
      send_sample(12'd2048, 12'd1000, 32'hDEAD_BEEF);
      drain();
      program_settings(16'd1000, 16'd30000, 24'd40000, 32'd300, 9'd256);
      send_sample(12'd62, 12'd1875, 32'h0123_4567);
      send_sample(12'd4095, 12'd0, 32'hFFFF_0000);
      drain();
      program_settings(16'd0, 16'd0, 24'd0, 32'd0, 9'd1);
      send_sample(12'd0, 12'd0, 32'h0000_8000);
      drain();
   endtask

   // Random settings, loads and samples near sources and receivers.
   task automatic test_random(int n_items);
      int i;
      i = 0;
      while (i < n_items) begin
         logic [23:0] rad;
         logic [31:0] scl;
         case ($urandom_range(3))
            0: rad = 24'($urandom_range(64));
            1: rad = 24'($urandom_range(4096));
            2: rad = 24'($urandom_range(1 << 20));
            default: rad = 24'($urandom);
         endcase
         // mostly a scale that spreads the radius over the table
         if ($urandom_range(3) == 0) scl = $urandom;
         else scl = 32'((64'd1023 << 24) / ((longint'(rad) << 8) + 1));
         program_settings(16'($urandom), 16'($urandom), rad, scl,
                          9'($urandom_range(300)));
         for (int k = 0; k < 60 && i < n_items; k++, i++) begin
            grad_item_type it;
            int            pick;
            it.operation  = ($urandom_range(99) < 35) ? srgt_pkg::OP_LOAD : srgt_pkg::OP_TAPER;
            it.slot       = 8'($urandom);
            it.col        = 12'($urandom);
            it.row        = 12'($urandom);
            it.grad_value = $urandom;
            if (it.operation == srgt_pkg::OP_TAPER && $urandom_range(2) != 0) begin
               // land near a receiver or the source to get inside the radius
               pick = $urandom_range(RCV_SLOTS);
               if (pick == RCV_SLOTS) begin
                  it.col = 12'(src_col_q4 >> 4) + 12'($urandom_range(16)) - 12'd8;
                  it.row = 12'(src_row_q4 >> 4) + 12'($urandom_range(16)) - 12'd8;
               end else begin
                  it.col = rx_col[pick] + 12'($urandom_range(16)) - 12'd8;
                  it.row = rx_row[pick] + 12'($urandom_range(16)) - 12'd8;
               end
            end
            send_item(it);
         end
         drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 23; recv_idle_pct = 49;
      test_after_reset();
      test_fill_table();
      test_extremes();
      test_random(295);
      send_idle_pct = 49; recv_idle_pct = 23;
      test_random(295);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(295);
      drain();
      if (fail_count == 0) $display("source_receiver_gradient_taper_tb: clean");
      else $display("source_receiver_gradient_taper_tb: errors");
      $finish;
   end

endmodule
